// ===== design/bc5_block_encoder_core_defines.svh =====
// Assertion macros shared by the BC5 block encoder RTL.
// Each macro expects i_clk and i_rst_n in the scope of its use.
`ifndef BC5_BLOCK_ENCODER_CORE_DEFINES_SVH
`define BC5_BLOCK_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BC5_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BC5_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bc5_pkg.sv =====
// Package for the BC5 block encoder: payload types, sizes and palette math.
// No dependencies.
`default_nettype none
package bc5_pkg;

    localparam int PIX_PER_BLOCK = 16;
    localparam int PAL_SIZE      = 8;
    localparam int CHAN_W        = 8;
    localparam int IDX_W         = 3;
    localparam int PAL_W         = 11;
    localparam int CNT_W         = 4;
    localparam int IDX_BITS      = PIX_PER_BLOCK * IDX_W;
    localparam int DEF_LANES     = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_x;
        logic [CHAN_W-1:0] chan_y;
    } t_pixel;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_block;

    typedef struct packed {
        logic [CHAN_W-1:0] x_hi;
        logic [CHAN_W-1:0] x_lo;
        logic [CHAN_W-1:0] y_hi;
        logic [CHAN_W-1:0] y_lo;
    } t_extrema;

    typedef struct packed {
        logic en;
        logic last;
    } t_enc_ctl;

    typedef logic [PAL_SIZE-1:0][PAL_W-1:0] t_pal;

    function automatic logic [PAL_W-1:0] times7(input logic [CHAN_W-1:0] v);
        logic [PAL_W-1:0] w;
        w = {3'b000, v};
        return (w << 3) - w;
    endfunction

    // Entry 0 is 7*hi, entry 1 is 7*lo, entry k+1 is 7*hi - k*(hi-lo).
    function automatic logic [PAL_W-1:0] pal_entry(input logic [CHAN_W-1:0] hi,
                                                   input logic [CHAN_W-1:0] lo,
                                                   input logic [IDX_W-1:0]  j);
        logic [PAL_W-1:0] d;
        logic [PAL_W-1:0] k;
        logic [PAL_W-1:0] e;
        d = {3'b000, hi - lo};
        k = PAL_W'(j) - PAL_W'(1);
        case (j)
            IDX_W'(0): e = times7(hi);
            IDX_W'(1): e = times7(lo);
            default:   e = times7(hi) - PAL_W'(k * d);
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== design/bc5_lane.sv =====
// One channel lane: nearest palette entry for one 8-bit value.
// Depends on bc5_pkg.
`default_nettype none
module bc5_lane (
    input  wire logic [bc5_pkg::CHAN_W-1:0] i_val,
    input  wire bc5_pkg::t_pal              i_pal,
    output logic [bc5_pkg::IDX_W-1:0]       o_idx
);

    logic [bc5_pkg::PAL_W-1:0] w_p7;
    logic [bc5_pkg::PAL_W-1:0] w_dist [bc5_pkg::PAL_SIZE];
    logic [bc5_pkg::PAL_W-1:0] w_d1 [4];
    logic [bc5_pkg::IDX_W-1:0] w_i1 [4];
    logic [bc5_pkg::PAL_W-1:0] w_d2 [2];
    logic [bc5_pkg::IDX_W-1:0] w_i2 [2];

    assign w_p7 = bc5_pkg::times7(i_val);

    always_comb begin
        for (int j = 0; j < bc5_pkg::PAL_SIZE; j++) begin
            w_dist[j] = (w_p7 >= i_pal[j]) ? (w_p7 - i_pal[j]) : (i_pal[j] - w_p7);
        end
    end

    // lower index wins ties at every level of the tree
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            if (w_dist[2*n+1] < w_dist[2*n]) begin
                w_d1[n] = w_dist[2*n+1];
                w_i1[n] = bc5_pkg::IDX_W'(2*n+1);
            end else begin
                w_d1[n] = w_dist[2*n];
                w_i1[n] = bc5_pkg::IDX_W'(2*n);
            end
        end
        for (int n = 0; n < 2; n++) begin
            if (w_d1[2*n+1] < w_d1[2*n]) begin
                w_d2[n] = w_d1[2*n+1];
                w_i2[n] = w_i1[2*n+1];
            end else begin
                w_d2[n] = w_d1[2*n];
                w_i2[n] = w_i1[2*n];
            end
        end
        if (w_d2[1] < w_d2[0]) begin
            o_idx = w_i2[1];
        end else begin
            o_idx = w_i2[0];
        end
    end

endmodule
`default_nettype wire

// ===== design/bc5_merge.sv =====
// Merge stage: gathers lane indices per step and registers the finished block.
// Depends on bc5_pkg.
`default_nettype none
module bc5_merge #(
    parameter int LANES = bc5_pkg::DEF_LANES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bc5_pkg::t_enc_ctl             i_ctl,
    input  wire bc5_pkg::t_extrema             i_ext,
    input  wire logic [LANES*bc5_pkg::IDX_W-1:0] i_lane_x,
    input  wire logic [LANES*bc5_pkg::IDX_W-1:0] i_lane_y,
    output logic                               o_valid,
    output bc5_pkg::t_block                    o_block
);

    localparam int IB = bc5_pkg::IDX_BITS;
    localparam int LB = LANES * bc5_pkg::IDX_W;

    logic [IB-1:0]    r_idx_x;
    logic [IB-1:0]    r_idx_y;
    logic [IB-1:0]    n_idx_x;
    logic [IB-1:0]    n_idx_y;
    logic [IB+LB-1:0] w_cat_x;
    logic [IB+LB-1:0] w_cat_y;
    logic             r_valid;
    bc5_pkg::t_block  r_block;

    // append this step's lanes at the top, drop the oldest bits
    assign w_cat_x = {i_lane_x, r_idx_x};
    assign w_cat_y = {i_lane_y, r_idx_y};
    assign n_idx_x = w_cat_x[LB +: IB];
    assign n_idx_y = w_cat_y[LB +: IB];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_idx_x <= n_idx_x;
            r_idx_y <= n_idx_y;
        end
        if (i_ctl.en && i_ctl.last) begin
            r_block.block_low  <= {n_idx_y, i_ext.y_lo, i_ext.y_hi};
            r_block.block_high <= {n_idx_x, i_ext.x_lo, i_ext.x_hi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.en & i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

endmodule
`default_nettype wire

// ===== design/bc5_block_encoder_core.sv =====
// BC5 block encoder top level: pixel store, extrema, palette and lane array.
// After the 16th pixel transfer the core runs the palette state, then the lane steps;
// the merge stage registers the result strobe on the last step. Throughput: one pixel
// per cycle while loading; busy then holds through the palette state and the lane steps.
// Reset is synchronous; it clears the pixel count, extrema, state and strobe.
// Depends on bc5_pkg, bc5_lane, bc5_merge and bc5_block_encoder_core_defines.svh.
`default_nettype none
`include "bc5_block_encoder_core_defines.svh"
module bc5_block_encoder_core #(
    parameter int LANES = bc5_pkg::DEF_LANES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire bc5_pkg::t_pixel i_pixel,
    output logic                 o_busy,
    output logic                 o_valid,
    output bc5_pkg::t_block      o_block
);

    localparam int NPIX      = bc5_pkg::PIX_PER_BLOCK;
    localparam int ENC_STEPS = NPIX / LANES;
    localparam int STEP_W    = (ENC_STEPS > 1) ? $clog2(ENC_STEPS) : 1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_PAL  = 2'd1;
    localparam logic [1:0] ST_ENC  = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [bc5_pkg::CNT_W-1:0] r_count;
    logic [STEP_W-1:0]         r_step;
    bc5_pkg::t_extrema         r_ext;
    bc5_pkg::t_extrema         n_ext;
    bc5_pkg::t_extrema         r_snap;
    bc5_pkg::t_pixel           r_store [NPIX];
    bc5_pkg::t_pal             r_pal_x;
    bc5_pkg::t_pal             r_pal_y;
    bc5_pkg::t_enc_ctl         w_ctl;
    logic                      w_accept;
    logic                      w_blk_end;
    logic [LANES*bc5_pkg::IDX_W-1:0] w_lane_x;
    logic [LANES*bc5_pkg::IDX_W-1:0] w_lane_y;

    assign o_busy    = (r_state != ST_LOAD);
    assign w_accept  = i_start & ~o_busy;
    assign w_blk_end = w_accept && (r_count == bc5_pkg::CNT_W'(NPIX - 1));
    assign w_ctl     = '{en: (r_state == ST_ENC), last: (r_step == STEP_W'(ENC_STEPS - 1))};

    always_comb begin
        n_ext = r_ext;
        if (i_pixel.chan_x > r_ext.x_hi) n_ext.x_hi = i_pixel.chan_x;
        if (i_pixel.chan_x < r_ext.x_lo) n_ext.x_lo = i_pixel.chan_x;
        if (i_pixel.chan_y > r_ext.y_hi) n_ext.y_hi = i_pixel.chan_y;
        if (i_pixel.chan_y < r_ext.y_lo) n_ext.y_lo = i_pixel.chan_y;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_blk_end) n_state = ST_PAL;
            end
            ST_PAL:  n_state = ST_ENC;
            ST_ENC: begin
                if (w_ctl.last) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_step  <= '0;
            r_ext   <= '{x_hi: '0, x_lo: '1, y_hi: '0, y_lo: '1};
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= r_count + 1'b1;
                if (w_blk_end) begin
                    r_ext <= '{x_hi: '0, x_lo: '1, y_hi: '0, y_lo: '1};
                end else begin
                    r_ext <= n_ext;
                end
            end
            if (r_state == ST_ENC) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_blk_end) begin
            r_snap <= n_ext;
        end
        if (r_state == ST_PAL) begin
            for (int j = 0; j < bc5_pkg::PAL_SIZE; j++) begin
                r_pal_x[j] <= bc5_pkg::pal_entry(r_snap.x_hi, r_snap.x_lo,
                                                 bc5_pkg::IDX_W'(j));
                r_pal_y[j] <= bc5_pkg::pal_entry(r_snap.y_hi, r_snap.y_lo,
                                                 bc5_pkg::IDX_W'(j));
            end
        end
        if (w_accept) begin
            r_store[r_count] <= i_pixel;
        end else if (w_ctl.en) begin
            // advance the store by one lane group
            for (int i = 0; i < NPIX - LANES; i++) begin
                r_store[i] <= r_store[i + LANES];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bc5_lane u_lane_x (
            .i_val (r_store[l].chan_x),
            .i_pal (r_pal_x),
            .o_idx (w_lane_x[l*bc5_pkg::IDX_W +: bc5_pkg::IDX_W])
        );
        bc5_lane u_lane_y (
            .i_val (r_store[l].chan_y),
            .i_pal (r_pal_y),
            .o_idx (w_lane_y[l*bc5_pkg::IDX_W +: bc5_pkg::IDX_W])
        );
    end

    bc5_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_ext    (r_snap),
        .i_lane_x (w_lane_x),
        .i_lane_y (w_lane_y),
        .o_valid  (o_valid),
        .o_block  (o_block)
    );

    `BC5_ASSERT_NEXT(a_blk_end_busy, w_blk_end, o_busy && (r_count == '0),
        "last pixel transfer did not start encoding")
    `BC5_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid,
        "result strobe held longer than one cycle")
    `BC5_ASSERT_NOW(a_strobe_after_enc, o_valid,
        !o_busy && ($past(r_state) == ST_ENC),
        "result strobe without a finished encode")
    `BC5_ASSERT_NOW(a_snap_order, r_state == ST_ENC,
        (r_snap.x_hi >= r_snap.x_lo) && (r_snap.y_hi >= r_snap.y_lo),
        "block extrema out of order during encode")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bc5_block_encoder_core: streams 4x4 pixel blocks and
// checks every encoded block against a behavioral palette encoder kept here.
// Depends on bc5_pkg and the encoder RTL.
module testbench;

    localparam int RANDOM_BLOCKS = 119;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LIMIT_NS      = 2_000_000;
    localparam int REPORT_MAX    = 10;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    bc5_pkg::t_pixel i_pixel = '0;
    logic            o_busy;
    logic            o_valid;
    bc5_pkg::t_block o_block;

    bc5_pkg::t_pixel pixel_queue[$];
    bc5_pkg::t_block expected_blocks[$];
    bc5_pkg::t_block want_block;
    int           total_pixels   = 0;
    int           sent_pixels    = 0;
    int           blocks_checked = 0;
    int           mismatches     = 0;
    int           idle_pct       = 0;
    int           fill           = 0;
    logic [127:0] x_seen         = '0;
    logic [127:0] y_seen         = '0;
    logic [7:0]   x_hi           = 8'd0;
    logic [7:0]   x_lo           = 8'd255;
    logic [7:0]   y_hi           = 8'd0;
    logic [7:0]   y_lo           = 8'd255;

    bc5_block_encoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_pixel (i_pixel),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_block (o_block)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] encode_channel(input logic [7:0] hi, input logic [7:0] lo,
                                                   input logic [127:0] vals);
        int         level[bc5_pkg::PAL_SIZE];
        int         span;
        int         scaled;
        int         best;
        int         gap;
        int         pick;
        logic [63:0] word;
        span     = int'(hi) - int'(lo);
        level[0] = 7 * int'(hi);
        level[1] = 7 * int'(lo);
        for (int k = 1; k <= 6; k++) begin
            level[k + 1] = 7 * int'(hi) - k * span;
        end
        word        = '0;
        word[7:0]   = hi;
        word[15:8]  = lo;
        for (int i = 0; i < bc5_pkg::PIX_PER_BLOCK; i++) begin
            scaled = 7 * int'(vals[8*i +: 8]);
            best   = 32'h7fff_ffff;
            pick   = 0;
            for (int j = 0; j < bc5_pkg::PAL_SIZE; j++) begin
                gap = (scaled >= level[j]) ? scaled - level[j] : level[j] - scaled;
                if (gap < best) begin
                    best = gap;
                    pick = j;
                end
            end
            word[16 + 3*i +: 3] = pick[2:0];
        end
        return word;
    endfunction

    task automatic take_pixel(input bc5_pkg::t_pixel px);
        bc5_pkg::t_block blk;
        x_seen[8*fill +: 8] = px.chan_x;
        y_seen[8*fill +: 8] = px.chan_y;
        if (px.chan_x > x_hi) x_hi = px.chan_x;
        if (px.chan_x < x_lo) x_lo = px.chan_x;
        if (px.chan_y > y_hi) y_hi = px.chan_y;
        if (px.chan_y < y_lo) y_lo = px.chan_y;
        if (fill == bc5_pkg::PIX_PER_BLOCK - 1) begin
            blk.block_low  = encode_channel(y_hi, y_lo, y_seen);
            blk.block_high = encode_channel(x_hi, x_lo, x_seen);
            expected_blocks.push_back(blk);
            fill = 0;
            x_hi = 8'd0;
            x_lo = 8'd255;
            y_hi = 8'd0;
            y_lo = 8'd255;
        end else begin
            fill++;
        end
    endtask

    function automatic logic [7:0] gen_value(input int mode, input int base, input int span);
        logic [7:0] v;
        case (mode)
            0:       v = 8'($urandom_range(255));
            1:       v = 8'(base + $urandom_range(span));
            2:       v = 8'(base);
            default: v = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                take_pixel(i_pixel);
                sent_pixels++;
            end
            idle_pct = (sent_pixels < total_pixels / 3)     ? 25 :
                       (sent_pixels < 2 * total_pixels / 3) ? 87 : 0;
            if (!(i_start && o_busy)) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_start <= 1'b1;
                    i_pixel <= pixel_queue.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected block low=%h high=%h",
                             o_block.block_low, o_block.block_high);
            end else begin
                want_block = expected_blocks.pop_front();
                blocks_checked++;
                if (o_block.block_low !== want_block.block_low ||
                    o_block.block_high !== want_block.block_high) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("block %0d: low exp %h got %h, high exp %h got %h",
                                 blocks_checked, want_block.block_low, o_block.block_low,
                                 want_block.block_high, o_block.block_high);
                end
            end
        end
    end

    initial begin
        bc5_pkg::t_pixel px;
        int     x_mode;
        int     y_mode;
        int     x_base;
        int     y_base;
        int     x_span;
        int     y_span;
        int     pick;
        // flat x pinned at the top code, y sweeping the full range
        for (int i = 0; i < bc5_pkg::PIX_PER_BLOCK; i++) begin
            px.chan_x = 8'd255;
            px.chan_y = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'(i * 17 - 9);
            pixel_queue.push_back(px);
        end
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            for (int c = 0; c < 2; c++) begin
                pick = $urandom_range(9);
                if (pick <= 2)      y_mode = 0;
                else if (pick <= 5) y_mode = 1;
                else if (pick == 6) y_mode = 2;
                else if (pick == 7) y_mode = 3;
                else                y_mode = 4;
                y_span = (y_mode == 4) ? $urandom_range(60, 8) : $urandom_range(7, 1);
                y_base = $urandom_range(255 - y_span);
                if (y_mode == 4) y_mode = 1;
                if (c == 0) begin
                    x_mode = y_mode;
                    x_span = y_span;
                    x_base = y_base;
                end
            end
            for (int i = 0; i < bc5_pkg::PIX_PER_BLOCK; i++) begin
                px.chan_x = gen_value(x_mode, x_base, x_span);
                px.chan_y = gen_value(y_mode, y_base, y_span);
                pixel_queue.push_back(px);
            end
        end
        total_pixels = pixel_queue.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pixel_queue.size() != 0 || i_start || expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d encoded blocks from %0d pixel transfers, %0d mismatches",
                 blocks_checked, sent_pixels, mismatches);
        $display("sender idled 25 then 87 of 100 cycles, then streamed back to back");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
